/* hdl/force_flux_stiffened_gas_core_defines.svh */
// ----------------------------------------------------------------------------
// force_flux_stiffened_gas_core_defines
// Assertion macros shared by the flux core modules.
// ----------------------------------------------------------------------------
`ifndef FORCE_FLUX_STIFFENED_GAS_CORE_DEFINES_SVH
`define FORCE_FLUX_STIFFENED_GAS_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ffs_pkg.sv */
// ----------------------------------------------------------------------------
// ffs_pkg
// Types, latencies and saturating fixed-point helpers for the flux core.
// ----------------------------------------------------------------------------
package ffs_pkg;

    localparam int FRAC_BITS = 24;
    localparam int WORD_BITS = 64;

    localparam int MUL_LAT   = 2;
    localparam int DIV_LAT   = WORD_BITS + 2;
    localparam int FLUX_LAT  = DIV_LAT + 3 * MUL_LAT;
    localparam int BACK_LAT  = 2 * FLUX_LAT + MUL_LAT;
    localparam int Q_DEPTH   = 4;

    typedef logic signed [WORD_BITS-1:0] word_t;
    // index 0 density, 1 momentum, 2 energy
    typedef logic [2:0][WORD_BITS-1:0] cons_t;

    typedef struct packed {
        cons_t lft;
        cons_t rgt;
        logic  err;
    } item_t;

    typedef enum logic [1:0] {
        CFG_GAMMA = 2'd0,
        CFG_PINF  = 2'd1,
        CFG_DTDX  = 2'd2,
        CFG_DXDT  = 2'd3
    } cfg_idx_t;

    localparam word_t MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t MINV = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t ONE  = word_t'(64'd1 << FRAC_BITS);

    function automatic word_t sat_add(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? MINV : MAXV;
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t sat_sub(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? MINV : MAXV;
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t half(input word_t x);
        word_t t;
        t = x + word_t'({{(WORD_BITS-1){1'b0}}, x[WORD_BITS-1]});
        return t >>> 1;
    endfunction

endpackage

/* hdl/force_flux_stiffened_gas_core.sv */
// ----------------------------------------------------------------------------
// force_flux_stiffened_gas_core
// FORCE interface flux for 1D Euler with a stiffened-gas law, Q40.24.
// ----------------------------------------------------------------------------
// One interface beat in, one flux beat out, sustained at one beat per clock
// while the output is not stalled. The pipeline depth is set by the two
// chained flux stages, each led by a 64-stage pipelined divider (one quotient
// bit per stage). A 4-beat input queue decouples acceptance from the execution
// pipeline, which freezes as a whole while the output register is stalled.
// Write configuration only while no beats are in flight.
module force_flux_stiffened_gas_core
    import ffs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [62:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [62:0] left_density,
    input  word_t       left_momentum,
    input  word_t       left_energy,
    input  logic [62:0] right_density,
    input  word_t       right_momentum,
    input  word_t       right_energy,
    output logic        out_valid,
    input  logic        out_stall,
    output word_t       mass_flux,
    output word_t       momentum_flux,
    output word_t       energy_flux,
    output logic        density_error
);

    logic [30:0] gamma_reg;
    logic [62:0] pinf_reg;
    logic [62:0] dtdx_reg;
    logic [62:0] dxdt_reg;
    word_t       g;
    word_t       gm1;
    word_t       gp;
    item_t       head;
    logic        head_valid;
    logic        pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= 31'd119957094;
            pinf_reg  <= 63'd5033164800000000;
            dtdx_reg  <= '0;
            dxdt_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAMMA: gamma_reg <= cfg_data[30:0];
                CFG_PINF:  pinf_reg  <= cfg_data;
                CFG_DTDX:  dtdx_reg  <= cfg_data;
                CFG_DXDT:  dxdt_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign g   = word_t'({33'd0, gamma_reg});
    assign gm1 = sat_sub(g, ONE);

    ffs_mul u_mul_gp (.clk(clk), .en(1'b1), .a(g), .b(word_t'({1'b0, pinf_reg})), .y(gp));

    ffs_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .left_density   (left_density),
        .left_momentum  (left_momentum),
        .left_energy    (left_energy),
        .right_density  (right_density),
        .right_momentum (right_momentum),
        .right_energy   (right_energy),
        .head           (head),
        .head_valid     (head_valid),
        .pop            (pop)
    );

    ffs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .dtdx          (word_t'({1'b0, dtdx_reg})),
        .dxdt          (word_t'({1'b0, dxdt_reg})),
        .gm1           (gm1),
        .gp            (gp),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mass_flux     (mass_flux),
        .momentum_flux (momentum_flux),
        .energy_flux   (energy_flux),
        .density_error (density_error)
    );

endmodule

/* hdl/ffs_mul.sv */
// ----------------------------------------------------------------------------
// ffs_mul
// Two-stage saturating fixed-point multiplier built from 32x32 partials.
// ----------------------------------------------------------------------------
module ffs_mul
    import ffs_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  word_t a,
    input  word_t b,
    output word_t y
);

    localparam int HW = WORD_BITS / 2;

    logic [WORD_BITS-1:0]   ua;
    logic [WORD_BITS-1:0]   ub;
    logic [WORD_BITS-1:0]   p00_reg;
    logic [WORD_BITS-1:0]   p01_reg;
    logic [WORD_BITS-1:0]   p10_reg;
    logic [WORD_BITS-1:0]   p11_reg;
    logic                   neg_reg;
    logic [2*WORD_BITS-1:0] full;
    logic [2*WORD_BITS-1:0] sh;
    logic [WORD_BITS-1:0]   lim;
    logic [WORD_BITS-1:0]   mag_s;
    word_t                  y_next;
    word_t                  y_reg;

    assign ua = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
    assign ub = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= WORD_BITS'(ua[HW-1:0] * ub[HW-1:0]);
            p01_reg <= WORD_BITS'(ua[HW-1:0] * ub[WORD_BITS-1:HW]);
            p10_reg <= WORD_BITS'(ua[WORD_BITS-1:HW] * ub[HW-1:0]);
            p11_reg <= WORD_BITS'(ua[WORD_BITS-1:HW] * ub[WORD_BITS-1:HW]);
            neg_reg <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
        end
    end

    always_comb
    begin
        full = {{WORD_BITS{1'b0}}, p00_reg}
             + ({{WORD_BITS{1'b0}}, p01_reg} << HW)
             + ({{WORD_BITS{1'b0}}, p10_reg} << HW)
             + {p11_reg, {WORD_BITS{1'b0}}};
        sh   = full >> FRAC_BITS;
        lim  = neg_reg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
        mag_s = ((|sh[2*WORD_BITS-1:WORD_BITS]) || (sh[WORD_BITS-1:0] > lim))
              ? lim : sh[WORD_BITS-1:0];
        y_next = neg_reg ? word_t'(-mag_s) : word_t'(mag_s);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

/* hdl/ffs_div.sv */
// ----------------------------------------------------------------------------
// ffs_div
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module ffs_div
    import ffs_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  word_t a,
    input  word_t b,
    output word_t y
);

    typedef struct packed {
        logic [WORD_BITS-1:0] rem;
        logic [WORD_BITS-1:0] num;
        logic [WORD_BITS-1:0] quo;
        logic [WORD_BITS-1:0] dvs;
        logic                 neg;
        logic                 ovf;
    } div_st_t;

    function automatic div_st_t div_step(input div_st_t s);
        div_st_t           r;
        logic [WORD_BITS:0] trial;
        logic              ge;
        r     = s;
        trial = {s.rem, s.num[WORD_BITS-1]};
        ge    = trial >= {1'b0, s.dvs};
        r.rem = ge ? WORD_BITS'(trial - {1'b0, s.dvs}) : trial[WORD_BITS-1:0];
        r.num = s.num << 1;
        r.quo = {s.quo[WORD_BITS-2:0], ge};
        return r;
    endfunction

    logic [WORD_BITS-1:0] ua;
    logic [WORD_BITS-1:0] ub;
    div_st_t              st_next;
    div_st_t              st_reg [0:WORD_BITS];
    logic [WORD_BITS-1:0] lim;
    logic [WORD_BITS-1:0] mag_s;
    word_t                y_next;
    word_t                y_reg;

    always_comb
    begin
        ua          = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
        ub          = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);
        st_next.rem = {{(WORD_BITS-FRAC_BITS){1'b0}}, ua[WORD_BITS-1:WORD_BITS-FRAC_BITS]};
        st_next.num = {ua[WORD_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        st_next.quo = '0;
        st_next.dvs = ub;
        st_next.neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        st_next.ovf = st_next.rem >= ub;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= st_next;
            for (int k = 1; k <= WORD_BITS; k++)
                st_reg[k] <= div_step(st_reg[k-1]);
        end
    end

    always_comb
    begin
        lim   = st_reg[WORD_BITS].neg ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                      : {1'b0, {(WORD_BITS-1){1'b1}}};
        mag_s = (st_reg[WORD_BITS].ovf || (st_reg[WORD_BITS].quo > lim))
              ? lim : st_reg[WORD_BITS].quo;
        y_next = st_reg[WORD_BITS].neg ? word_t'(-mag_s) : word_t'(mag_s);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

/* hdl/ffs_flux.sv */
// ----------------------------------------------------------------------------
// ffs_flux
// Pipelined physical Euler flux with stiffened-gas pressure.
// ----------------------------------------------------------------------------
module ffs_flux
    import ffs_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  cons_t u,
    input  word_t gm1,
    input  word_t gp,
    output cons_t f
);

    localparam int E_LEN = DIV_LAT + 2 * MUL_LAT;

    word_t m_d_reg  [0:FLUX_LAT-1];
    word_t e_d_reg  [0:E_LEN-1];
    word_t v_d_reg  [0:2*MUL_LAT-1];
    word_t mv_d_reg [0:MUL_LAT-1];
    word_t f1_d_reg [0:MUL_LAT-1];
    word_t v;
    word_t mv;
    word_t p1;
    word_t t_c;
    word_t p;
    word_t f1c;
    word_t ep;
    word_t f2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_d_reg[0]  <= u[1];
            e_d_reg[0]  <= u[2];
            v_d_reg[0]  <= v;
            mv_d_reg[0] <= mv;
            f1_d_reg[0] <= f1c;
            for (int k = 1; k < FLUX_LAT; k++)
                m_d_reg[k] <= m_d_reg[k-1];
            for (int k = 1; k < E_LEN; k++)
                e_d_reg[k] <= e_d_reg[k-1];
            for (int k = 1; k < 2 * MUL_LAT; k++)
                v_d_reg[k] <= v_d_reg[k-1];
            for (int k = 1; k < MUL_LAT; k++)
            begin
                mv_d_reg[k] <= mv_d_reg[k-1];
                f1_d_reg[k] <= f1_d_reg[k-1];
            end
        end
    end

    ffs_div u_div (.clk(clk), .en(en), .a(u[1]), .b(u[0]), .y(v));

    ffs_mul u_mul_mv (.clk(clk), .en(en), .a(m_d_reg[DIV_LAT-1]), .b(v), .y(mv));

    assign t_c = sat_sub(e_d_reg[DIV_LAT+MUL_LAT-1], half(mv));

    ffs_mul u_mul_p (.clk(clk), .en(en), .a(gm1), .b(t_c), .y(p1));

    assign p   = sat_sub(p1, gp);
    assign f1c = sat_add(mv_d_reg[MUL_LAT-1], p);
    assign ep  = sat_add(e_d_reg[E_LEN-1], p);

    ffs_mul u_mul_e (.clk(clk), .en(en), .a(ep), .b(v_d_reg[2*MUL_LAT-1]), .y(f2));

    assign f[0] = m_d_reg[FLUX_LAT-1];
    assign f[1] = f1_d_reg[MUL_LAT-1];
    assign f[2] = f2;

endmodule

/* hdl/ffs_front.sv */
// ----------------------------------------------------------------------------
// ffs_front
// Input side: accept a beat, flag zero densities, queue it for the back end.
// ----------------------------------------------------------------------------
`include "force_flux_stiffened_gas_core_defines.svh"

module ffs_front
    import ffs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [62:0] left_density,
    input  word_t       left_momentum,
    input  word_t       left_energy,
    input  logic [62:0] right_density,
    input  word_t       right_momentum,
    input  word_t       right_energy,
    output item_t       head,
    output logic        head_valid,
    input  logic        pop
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    item_t          q_reg [0:Q_DEPTH-1];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           push;
    item_t          item;

    always_comb
    begin
        item.lft[0] = {1'b0, left_density};
        item.lft[1] = left_momentum;
        item.lft[2] = left_energy;
        item.rgt[0] = {1'b0, right_density};
        item.rgt[1] = right_momentum;
        item.rgt[2] = right_energy;
        item.err    = (left_density == '0) || (right_density == '0);
    end

    assign in_stall   = (count_reg == CW'(Q_DEPTH));
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    `FFS_ASSERT_IMP(a_pop_nonempty, pop, count_reg != '0, "pop from empty queue")
    `FFS_ASSERT_NXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "count lost")
    `FFS_ASSERT_IMP(a_no_overfill, 1'b1, count_reg <= CW'(Q_DEPTH), "queue overfilled")

endmodule

/* hdl/ffs_back.sv */
// ----------------------------------------------------------------------------
// ffs_back
// Execution pipeline: side fluxes, Lax-Friedrichs and Richtmyer parts, output.
// ----------------------------------------------------------------------------
`include "force_flux_stiffened_gas_core_defines.svh"

module ffs_back
    import ffs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t head,
    input  logic  head_valid,
    output logic  pop,
    input  word_t dtdx,
    input  word_t dxdt,
    input  word_t gm1,
    input  word_t gp,
    output logic  out_valid,
    input  logic  out_stall,
    output word_t mass_flux,
    output word_t momentum_flux,
    output word_t energy_flux,
    output logic  density_error
);

    logic                adv;
    logic [BACK_LAT-1:0] vld_reg;
    item_t               it_d_reg  [0:FLUX_LAT-1];
    logic                err_d_reg [0:FLUX_LAT+MUL_LAT-1];
    logic                e2_d_reg  [0:FLUX_LAT-1];
    cons_t               s_d_reg   [0:MUL_LAT-1];
    cons_t               a_d_reg   [0:MUL_LAT-1];
    cons_t               lf_d_reg  [0:FLUX_LAT-1];
    cons_t               fl;
    cons_t               fr;
    cons_t               fu;
    cons_t               d_a;
    cons_t               d_b;
    cons_t               s_c;
    cons_t               a_c;
    cons_t               p_a;
    cons_t               p_b;
    cons_t               u_c;
    cons_t               lf_c;
    cons_t               res;
    logic                err_u;
    logic                ov_reg;
    logic                de_reg;
    word_t               mf_reg;
    word_t               pf_reg;
    word_t               ef_reg;

    assign adv = !ov_reg || !out_stall;
    assign pop = adv && head_valid;

    ffs_flux u_flux_l (.clk(clk), .en(adv), .u(head.lft), .gm1(gm1), .gp(gp), .f(fl));
    ffs_flux u_flux_r (.clk(clk), .en(adv), .u(head.rgt), .gm1(gm1), .gp(gp), .f(fr));

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_a[i] = sat_sub(fr[i], fl[i]);
            d_b[i] = sat_sub(it_d_reg[FLUX_LAT-1].lft[i], it_d_reg[FLUX_LAT-1].rgt[i]);
            s_c[i] = half(sat_add(fr[i], fl[i]));
            a_c[i] = half(sat_add(it_d_reg[FLUX_LAT-1].lft[i], it_d_reg[FLUX_LAT-1].rgt[i]));
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        ffs_mul u_mul_a (.clk(clk), .en(adv), .a(dtdx), .b(d_a[g]), .y(p_a[g]));
        ffs_mul u_mul_b (.clk(clk), .en(adv), .a(dxdt), .b(d_b[g]), .y(p_b[g]));
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_c[i]  = sat_sub(a_d_reg[MUL_LAT-1][i], half(p_a[i]));
            lf_c[i] = sat_add(half(p_b[i]), s_d_reg[MUL_LAT-1][i]);
            res[i]  = half(sat_add(lf_d_reg[FLUX_LAT-1][i], fu[i]));
        end
        err_u = err_d_reg[FLUX_LAT+MUL_LAT-1] || (u_c[0] == '0);
    end

    ffs_flux u_flux_u (.clk(clk), .en(adv), .u(u_c), .gm1(gm1), .gp(gp), .f(fu));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it_d_reg[0]  <= head;
            err_d_reg[0] <= head.err;
            s_d_reg[0]   <= s_c;
            a_d_reg[0]   <= a_c;
            lf_d_reg[0]  <= lf_c;
            e2_d_reg[0]  <= err_u;
            for (int k = 1; k < FLUX_LAT; k++)
            begin
                it_d_reg[k] <= it_d_reg[k-1];
                lf_d_reg[k] <= lf_d_reg[k-1];
                e2_d_reg[k] <= e2_d_reg[k-1];
            end
            for (int k = 1; k < FLUX_LAT + MUL_LAT; k++)
                err_d_reg[k] <= err_d_reg[k-1];
            for (int k = 1; k < MUL_LAT; k++)
            begin
                s_d_reg[k] <= s_d_reg[k-1];
                a_d_reg[k] <= a_d_reg[k-1];
            end
            de_reg <= e2_d_reg[FLUX_LAT-1];
            mf_reg <= e2_d_reg[FLUX_LAT-1] ? '0 : word_t'(res[0]);
            pf_reg <= e2_d_reg[FLUX_LAT-1] ? '0 : word_t'(res[1]);
            ef_reg <= e2_d_reg[FLUX_LAT-1] ? '0 : word_t'(res[2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[BACK_LAT-2:0], head_valid};
            ov_reg  <= vld_reg[BACK_LAT-1];
        end
    end

    assign out_valid     = ov_reg;
    assign density_error = de_reg;
    assign mass_flux     = mf_reg;
    assign momentum_flux = pf_reg;
    assign energy_flux   = ef_reg;

    `FFS_ASSERT_IMP(a_err_zero, ov_reg && de_reg, mf_reg == '0 && pf_reg == '0 && ef_reg == '0, "flux not cleared on density error")
    `FFS_ASSERT_NXT(a_hold, !adv, vld_reg == $past(vld_reg), "pipeline moved while held")
    `FFS_ASSERT_NXT(a_deliver, adv && vld_reg[BACK_LAT-1], ov_reg, "finished beat not presented")

endmodule
